FILE: design/tfud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfud_pkg
// shared types and constants of the telemetry frame unstuff decoder
// ----------------------------------------------------------------------------
package tfud_pkg;

	localparam int unsigned RAW_LEN   = 8;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 8;

	localparam logic [7:0] ESC_XOR           = 8'h20;
	localparam logic [7:0] FRAME_TYPE_RESET  = 8'd16;
	localparam logic [7:0] ESCAPE_BYTE_RESET = 8'd125;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 2'd1;

	// one classified beat handed from front to back
	typedef struct packed {
		logic       raw;   // data is an unstuffed raw byte to be kept
		logic [7:0] data;
		logic       last;  // final beat of the frame
		logic       hang;  // escape left pending at the final beat
	} tfud_entry_t;

	// end-around-carry add of one byte into the checksum accumulator
	function automatic logic [7:0] eac_add(input logic [7:0] acc, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, acc} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

FILE: design/tfud_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfud_front
// accepts received bytes, strips escapes and classifies each beat
// ----------------------------------------------------------------------------
module tfud_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           escape_byte,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic                 q_full,
	output logic                 in_ready,
	output logic                 push,
	output tfud_pkg::tfud_entry_t push_entry
);
	import tfud_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             pending_q;
	logic [CNT_W-1:0] count_nx;
	logic             pending_nx;
	logic             raw;
	logic [7:0]       data;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		raw        = 1'b0;
		data       = in_byte;
		count_nx   = count_q;
		pending_nx = pending_q;
		if (count_q < CNT_W'(RAW_LEN)) begin
			if (pending_q) begin
				raw        = 1'b1;
				data       = in_byte ^ ESC_XOR;
				count_nx   = count_q + 1'b1;
				pending_nx = 1'b0;
			end else if (in_byte == escape_byte) begin
				pending_nx = 1'b1;
			end else begin
				raw      = 1'b1;
				count_nx = count_q + 1'b1;
			end
		end
	end

	assign push_entry = '{raw: raw, data: data, last: in_last, hang: pending_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= 1'b0;
		end else if (push) begin
			if (in_last) begin
				count_q   <= '0;
				pending_q <= 1'b0;
			end else begin
				count_q   <= count_nx;
				pending_q <= pending_nx;
			end
		end
	end

endmodule

FILE: design/tfud_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfud_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module tfud_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tfud_pkg::tfud_entry_t push_entry,
	input  logic                  pop,
	output tfud_pkg::tfud_entry_t head,
	output logic                  empty,
	output logic                  full
);
	import tfud_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);

	tfud_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign empty = (level_q == '0);
	assign full  = (level_q == LVL_W'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(DEPTH))
		else $error("queue level beyond depth");

endmodule

FILE: design/tfud_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfud_back
// collects raw bytes, runs the checksum and forms the frame result
// ----------------------------------------------------------------------------
module tfud_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            frame_type_byte,
	input  logic                  q_empty,
	input  tfud_pkg::tfud_entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  frame_ok,
	output logic [15:0]           sensor_id,
	output logic [31:0]           sensor_value
);
	import tfud_pkg::*;

	localparam int unsigned IDX_W = $clog2(RAW_LEN);

	logic [7:0]       store_q [RAW_LEN];
	logic [CNT_W-1:0] count_q;
	logic [7:0]       acc_q;
	logic             valid_q;
	logic             ok_q;
	logic [15:0]      id_q;
	logic [31:0]      value_q;

	logic             wr;
	logic [IDX_W-1:0] idx;
	logic [CNT_W-1:0] count_nx;
	logic [7:0]       byte7;
	logic             ok;

	// a final beat needs a free result slot; other beats always drain
	assign pop = !q_empty && (!head.last || !valid_q || out_ready);
	assign wr  = pop && head.raw;
	assign idx = count_q[IDX_W-1:0];
	assign count_nx = wr ? count_q + 1'b1 : count_q;

	// the eighth raw byte may arrive on the final beat itself
	assign byte7 = (wr && idx == IDX_W'(RAW_LEN - 1)) ? head.data : store_q[RAW_LEN-1];
	assign ok = (count_nx == CNT_W'(RAW_LEN)) && !head.hang &&
		(store_q[0] == frame_type_byte) && (byte7 == ~acc_q);

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[idx] <= head.data;
		end
		if (pop && head.last) begin
			ok_q    <= ok;
			id_q    <= ok ? {store_q[2], store_q[1]} : 16'd0;
			value_q <= ok ? {store_q[6], store_q[5], store_q[4], store_q[3]} : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			acc_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.last) begin
					count_q <= '0;
					acc_q   <= '0;
					valid_q <= 1'b1;
				end else begin
					count_q <= count_nx;
					if (wr && idx != IDX_W'(RAW_LEN - 1)) begin
						acc_q <= eac_add(acc_q, head.data);
					end
				end
			end
		end
	end

	assign out_valid    = valid_q;
	assign frame_ok     = ok_q;
	assign sensor_id    = id_q;
	assign sensor_value = value_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RAW_LEN))
		else $error("raw count beyond frame length");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !ok_q) |-> (id_q == 16'd0 && value_q == 32'd0))
		else $error("failed frame carries nonzero payload");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |-> (!valid_q || out_ready))
		else $error("result slot overwritten before taken");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(RAW_LEN)) |-> !wr)
		else $error("raw byte written past frame length");

endmodule

FILE: design/telemetry_frame_unstuff_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_unstuff_decoder
// unstuffs a received telemetry frame and checks type and checksum
// ----------------------------------------------------------------------------
// Input stream s_*: one received byte per beat in s_tdata, s_tlast on the
// final byte of the frame. Output stream m_*: one result beat per frame,
// given after the final byte, with frame_ok, sensor id and sensor value.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 is the
// frame type byte, 1 the escape byte); write only while no frame is in flight.
// A front stage strips escapes and classifies each byte, a queue of
// QUEUE_DEPTH beats decouples it from a back stage that stores raw bytes,
// keeps the checksum and forms the result in an output register.
// Throughput: one input byte per cycle while s_tready is high. The result of a
// final byte passes through the queue and then the output register.
// When m_tready is low the result is held; bytes keep draining into the back
// stage until the next final byte reaches the queue head, then the queue
// fills and s_tready drops. Reset clears the frame state, the queue and the
// output valid flag and restores both configuration registers.
// ----------------------------------------------------------------------------
module telemetry_frame_unstuff_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tfud_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tfud_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
	input  logic                           s_tlast,   // frame_end
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [55:0]                    m_tdata    // [0] frame_ok, [16:1] sensor_id,
	                                                  // [48:17] sensor_value, rest zero
);
	import tfud_pkg::*;

	logic [7:0]  frame_type_q;
	logic [7:0]  escape_q;
	logic        push;
	logic        pop;
	logic        q_empty;
	logic        q_full;
	tfud_entry_t push_entry;
	tfud_entry_t head;
	logic        frame_ok;
	logic [15:0] sensor_id;
	logic [31:0] sensor_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q <= FRAME_TYPE_RESET;
			escape_q     <= ESCAPE_BYTE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_TYPE:  frame_type_q <= cfg_data;
				REG_ESCAPE_BYTE: escape_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	tfud_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.escape_byte(escape_q),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.q_full     (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_entry (push_entry)
	);

	tfud_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	tfud_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_type_byte(frame_type_q),
		.q_empty        (q_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.frame_ok       (frame_ok),
		.sensor_id      (sensor_id),
		.sensor_value   (sensor_value)
	);

	assign m_tdata = {7'd0, sensor_value, sensor_id, frame_ok};

endmodule

FILE: tb/telemetry_frame_unstuff_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_unstuff_decoder_tb
// self-checking bench for the telemetry frame unstuff decoder
// ----------------------------------------------------------------------------
// A short table of hand-written beats goes first. Random frames follow: half
// well formed, with random ids, values and escapes, and the rest with a wrong
// type, a bad checksum, a short length, extra bytes, a hanging escape or plain
// noise. This runs under several register settings and idling mixes, with one
// long receiver hold-off. A behavioral model predicts every result beat but for
// pinned rows; each is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module telemetry_frame_unstuff_decoder_tb;
	import tfud_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned PHASE_BEATS   = 130;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic        ok;
		logic [15:0] id;
		logic [31:0] value;
	} frame_result_t;

	typedef struct packed {
		logic [7:0]    data;
		logic          last;
		logic          pinned;   // result typed in below, not taken from the model
		frame_result_t res;
	} beat_row_t;

	localparam frame_result_t NO_FRAME  = '{1'b0, 16'h0000, 32'h0000_0000};
	localparam frame_result_t ALL_ONES  = '{1'b1, 16'hFFFF, 32'hFFFF_FFFF};

	localparam beat_row_t DIRECTED [23] = '{
		// one-byte frame
		'{8'h10, 1'b1, 1'b1, NO_FRAME},
		// all-ones id and value, checksum 0xef
		'{8'h10, 1'b0, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{8'hEF, 1'b1, 1'b1, ALL_ONES},
		// escaped escape, escape then escape, trailing escape after eight bytes
		'{8'h10, 1'b0, 1'b0, NO_FRAME},
		'{8'h7D, 1'b0, 1'b0, NO_FRAME},
		'{8'h5D, 1'b0, 1'b0, NO_FRAME},
		'{8'h7D, 1'b0, 1'b0, NO_FRAME},
		'{8'h7D, 1'b0, 1'b0, NO_FRAME},
		'{8'h01, 1'b0, 1'b0, NO_FRAME},
		'{8'h02, 1'b0, 1'b0, NO_FRAME},
		'{8'h03, 1'b0, 1'b0, NO_FRAME},
		'{8'h04, 1'b0, 1'b0, NO_FRAME},
		'{8'h0B, 1'b0, 1'b0, NO_FRAME},
		'{8'h7D, 1'b1, 1'b0, NO_FRAME},
		// escape left hanging on the last byte
		'{8'h10, 1'b0, 1'b0, NO_FRAME},
		'{8'h7D, 1'b1, 1'b1, NO_FRAME},
		// zero byte alone
		'{8'h00, 1'b1, 1'b1, NO_FRAME}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;

	// decoder model state
	logic [7:0]                type_m;
	logic [7:0]                esc_m;
	logic [RAW_LEN-1:0][7:0]   raw_m;
	logic [CNT_W-1:0]          count_m;
	logic                      pend_m;
	frame_result_t             frame_results_due [$];

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	int mismatches     = 0;
	int beats_sent     = 0;
	int frames_ok      = 0;
	int frames_bad     = 0;
	int settings_used  = 1;

	telemetry_frame_unstuff_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// 0xff minus the end-around-carry sum of bytes 0..6
	function automatic logic [7:0] check_byte_of(input logic [RAW_LEN-1:0][7:0] r);
		logic [8:0] s;
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < RAW_LEN - 1; i++) begin
			s   = {1'b0, acc} + {1'b0, r[i]};
			acc = s[7:0] + {7'd0, s[8]};
		end
		return 8'hFF - acc;
	endfunction

	task automatic unstuff_byte(input logic [7:0] b, input logic l, input logic pinned,
		input frame_result_t pin);
		frame_result_t r;
		if (count_m < RAW_LEN) begin
			if (pend_m) begin
				raw_m[count_m[2:0]] = b ^ ESC_XOR;
				count_m++;
				pend_m = 1'b0;
			end else if (b == esc_m) begin
				pend_m = 1'b1;
			end else begin
				raw_m[count_m[2:0]] = b;
				count_m++;
			end
		end
		if (l) begin
			r.ok    = count_m == RAW_LEN && !pend_m && raw_m[0] == type_m &&
			          raw_m[7] == check_byte_of(raw_m);
			r.id    = r.ok ? {raw_m[2], raw_m[1]} : 16'h0000;
			r.value = r.ok ? {raw_m[6], raw_m[5], raw_m[4], raw_m[3]} : 32'h0;
			frame_results_due.push_back(pinned ? pin : r);
			raw_m   = '0;
			count_m = '0;
			pend_m  = 1'b0;
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic l, input logic pinned,
		input frame_result_t pin);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
		unstuff_byte(b, l, pinned, pin);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		unique case (idx)
			REG_FRAME_TYPE:  type_m = val;
			REG_ESCAPE_BYTE: esc_m  = val;
			default: ;
		endcase
	endtask

	// wait until every result is in and the pipe has drained
	task automatic settle();
		s_tvalid <= 1'b0;
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// biased toward the escape byte and its xor partner
	function automatic logic [7:0] rand_byte();
		unique case ($urandom_range(7))
			0:       return esc_m;
			1:       return esc_m ^ ESC_XOR;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame(input bit short_only);
		logic [RAW_LEN-1:0][7:0] r;
		logic [7:0]              wire_q [$];
		int                      kind;
		int                      nraw;
		kind = $urandom_range(99);
		nraw = RAW_LEN;
		r[0] = type_m;
		for (int i = 1; i < RAW_LEN - 1; i++)
			r[i] = rand_byte();
		if (kind < 8)
			r[0] = type_m ^ 8'($urandom_range(1, 255));
		r[7] = check_byte_of(r);
		if (kind >= 8 && kind < 16)
			r[7] = r[7] ^ 8'($urandom_range(1, 255));
		if (kind >= 16 && kind < 30)
			nraw = $urandom_range(0, RAW_LEN - 1);
		if (short_only)
			nraw = $urandom_range(0, 2);
		for (int i = 0; i < nraw; i++) begin
			// escape what must be, and now and then what need not be
			if (r[i] == esc_m || $urandom_range(9) == 0) begin
				wire_q.push_back(esc_m);
				wire_q.push_back(r[i] ^ ESC_XOR);
			end else begin
				wire_q.push_back(r[i]);
			end
		end
		if (kind >= 24 && kind < 30)
			wire_q.push_back(esc_m);
		else if (kind >= 30 && kind < 42)
			repeat ($urandom_range(1, 3)) wire_q.push_back(rand_byte());
		if (kind >= 92) begin
			wire_q.delete();
			repeat ($urandom_range(1, 12)) wire_q.push_back(rand_byte());
		end
		if (wire_q.size() == 0)
			wire_q.push_back(rand_byte());
		foreach (wire_q[i])
			send_beat(wire_q[i], i == wire_q.size() - 1, 1'b0, NO_FRAME);
	endtask

	task automatic run_phase(input int src, input int sink, input logic [7:0] ftype,
		input logic [7:0] esc, input int budget);
		int first_beat;
		settle();
		write_reg(REG_FRAME_TYPE, ftype);
		write_reg(REG_ESCAPE_BYTE, esc);
		src_idle_pct   = src;
		sink_stall_pct = sink;
		settings_used++;
		first_beat = beats_sent;
		while (beats_sent - first_beat < budget)
			send_frame(1'b0);
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tlast   <= 1'b0;
		type_m    = FRAME_TYPE_RESET;
		esc_m     = ESCAPE_BYTE_RESET;
		raw_m     = '0;
		count_m   = '0;
		pend_m    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_beat(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].pinned, DIRECTED[i].res);

		run_phase(0, 0, FRAME_TYPE_RESET, ESCAPE_BYTE_RESET, PHASE_BEATS);
		run_phase(57, 0, 8'h00, 8'hFF, PHASE_BEATS);
		run_phase(0, 57, 8'hFF, 8'h00, PHASE_BEATS);

		// writes to the spare indexes must change nothing
		settle();
		write_reg(REG_SPARE_LO, 8'($urandom_range(255)));
		write_reg(REG_SPARE_HI, 8'($urandom_range(255)));
		run_phase(28, 28, 8'($urandom_range(255)), 8'($urandom_range(255)), PHASE_BEATS);

		// receiver holds off while short frames keep coming, so the input backs up
		settle();
		src_idle_pct = 0;
		hold_left    = HOLD_CYCLES;
		repeat (20) send_frame(1'b1);
		settle();

		$display("covered %0d input beats, %0d frame results (%0d passing, %0d failing)",
			beats_sent, frames_ok + frames_bad, frames_ok, frames_bad);
		$display("over %0d register settings, four idling mixes and one long hold-off",
			settings_used);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= $urandom_range(99) >= sink_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (m_tvalid && m_tready) begin
			if (frame_results_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with no frame pending, got %h", $time, m_tdata);
			end else begin
				want = frame_results_due.pop_front();
				if (want.ok)
					frames_ok++;
				else
					frames_bad++;
				if (m_tdata[0] !== want.ok) begin
					mismatches++;
					$display("%0t: frame_ok expected %0b got %0b", $time, want.ok, m_tdata[0]);
				end
				if (m_tdata[16:1] !== want.id) begin
					mismatches++;
					$display("%0t: sensor_id expected %h got %h", $time, want.id,
						m_tdata[16:1]);
				end
				if (m_tdata[48:17] !== want.value) begin
					mismatches++;
					$display("%0t: sensor_value expected %h got %h", $time, want.value,
						m_tdata[48:17]);
				end
				if (m_tdata[55:49] !== 7'h00) begin
					mismatches++;
					$display("%0t: pad bits expected 00 got %h", $time, m_tdata[55:49]);
				end
			end
		end
	end

	// no beat moving on either side for too long ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog, no beat moved in %0d cycles, %0d results pending",
				$time, QUIET_LIMIT, frame_results_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
